// ----- hdl/tns_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tns_pkg: shared types and constants of the tune note sequencer
// Table sizes, field widths, item modes and the structs passed between the
// sequencer modules.
// ----------------------------------------------------------------------------
package tns_pkg;

    // Table sizes and derived address widths.
    localparam int NOTE_SLOTS = 64;
    localparam int TONE_SLOTS = 64;
    localparam int NOTE_AW    = $clog2(NOTE_SLOTS);
    localparam int TONE_AW    = $clog2(TONE_SLOTS);
    localparam int POS_W      = $clog2(NOTE_SLOTS + 1);

    // Field widths.
    localparam int CODE_W    = 6;
    localparam int DUR_W     = 8;
    localparam int NOTE_W    = CODE_W + DUR_W;
    localparam int PERIOD_W  = 16;
    localparam int COMPARE_W = 15;
    localparam int LEN_W     = 7;
    localparam int CFG_W     = 7;

    // Item modes.
    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_START   = 2'd1,
        MODE_NOTE_WR = 2'd2,
        MODE_TONE_WR = 2'd3
    } t_mode;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_TUNE_LENGTH = 1'b0,
        CFG_REST_CODE   = 1'b1
    } t_cfg_idx;

    // Table write controls from the sequencer to the table memories.
    typedef struct packed {
        logic               note_we;
        logic [NOTE_AW-1:0] note_addr;
        logic [NOTE_W-1:0]  note_data;
        logic               tone_we;
        logic [TONE_AW-1:0] tone_addr;
        logic [PERIOD_W-1:0] tone_data;
    } t_tbl_wr;

    // One result beat.
    typedef struct packed {
        logic [PERIOD_W-1:0]  period;
        logic [COMPARE_W-1:0] compare;
        logic                 playing;
    } t_result;

endpackage
`default_nettype wire

// ----- hdl/tns_tables.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tns_tables: note and tone table memories
// The note table is read every cycle at the given position; the tone table
// is read every cycle at the code held in the registered note word, so the
// tone of the current note settles through r_note_q and then r_tone_q.
// ----------------------------------------------------------------------------
module tns_tables
    import tns_pkg::*;
(
    input  wire logic                i_clk,
    input  wire t_tbl_wr             i_wr,
    input  wire logic [NOTE_AW-1:0]  i_note_raddr,
    output logic      [NOTE_W-1:0]   o_note_q,
    output logic      [PERIOD_W-1:0] o_tone_q
);

    logic [NOTE_W-1:0]   r_note_mem [NOTE_SLOTS];
    logic [PERIOD_W-1:0] r_tone_mem [TONE_SLOTS];
    logic [NOTE_W-1:0]   r_note_q;
    logic [PERIOD_W-1:0] r_tone_q;
    logic [CODE_W-1:0]   note_code;

    assign note_code = r_note_q[NOTE_W-1 -: CODE_W];

    // Note table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr.note_we) begin
            r_note_mem[i_wr.note_addr] <= i_wr.note_data;
        end
        r_note_q <= r_note_mem[i_note_raddr];
    end

    // Tone table: read at the code of the registered note word.
    always_ff @(posedge i_clk) begin
        if (i_wr.tone_we) begin
            r_tone_mem[i_wr.tone_addr] <= i_wr.tone_data;
        end
        r_tone_q <= r_tone_mem[note_code[TONE_AW-1:0]];
    end

    assign o_note_q = r_note_q;
    assign o_tone_q = r_tone_q;

endmodule
`default_nettype wire

// ----- hdl/tns_out_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tns_out_queue: two-beat result queue
// Holds finished results so that a new item can be taken while the
// downstream side stalls.
// ----------------------------------------------------------------------------
module tns_out_queue
    import tns_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    input  wire logic    i_stall,
    output logic         o_valid,
    output t_result      o_data,
    output logic         o_full
);

    t_result     r_slot [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_slot[r_rd_ptr];
    assign pop     = o_valid && !i_stall;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Result storage; no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/tune_note_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tune_note_sequencer: tune player driven by timer ticks
// Plays notes from a note table, looking up each tone period in a tone
// table, and reports the tone period, duty compare and play flag per item.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  input     in         i_in_valid / o_in_stall   mode, slot, tone_code,
//                                                 length_ticks, period_value
//  output    out        o_out_valid / i_out_stall tone_period, tone_compare,
//                                                 playing
//  config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// One result beat leaves per accepted item.
// A tick that loads a note waits for the note and tone table reads to settle:
// after each note load or table write it stalls until the settle count
// r_fresh reaches FRESH_DONE, so such ticks cannot be taken back to back.
// A two-beat output queue lets input be taken while the output stalls.
// Reset is synchronous and active low; the tables are not cleared.
// ----------------------------------------------------------------------------
module tune_note_sequencer
    import tns_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Input channel.
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [1:0]           i_mode,
    input  wire logic [5:0]           i_slot,
    input  wire logic [CODE_W-1:0]    i_tone_code,
    input  wire logic [DUR_W-1:0]     i_length_ticks,
    input  wire logic [PERIOD_W-1:0]  i_period_value,
    // Output channel.
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [PERIOD_W-1:0]       o_tone_period,
    output logic [COMPARE_W-1:0]      o_tone_compare,
    output logic                      o_playing,
    // Configuration port.
    input  wire logic                 i_cfg_we,
    input  wire logic [0:0]           i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam logic [1:0] FRESH_DONE = 2'd2;

    // Sequencer state.
    logic [POS_W-1:0]     r_pos,     n_pos;
    logic [DUR_W-1:0]     r_ticks,   n_ticks;
    logic                 r_enabled, n_enabled;
    logic [PERIOD_W-1:0]  r_period,  n_period;
    logic [COMPARE_W-1:0] r_compare, n_compare;
    logic [1:0]           r_fresh,   n_fresh;
    logic [LEN_W-1:0]     r_tune_length;
    logic [CODE_W-1:0]    r_rest_code;

    t_mode                mode;
    t_tbl_wr              tbl_wr;
    t_result              push_data;
    t_result              out_data;
    logic                 q_full;
    logic                 accept;
    logic                 load_tick;
    logic [NOTE_W-1:0]    note_q;
    logic [PERIOD_W-1:0]  tone_q;
    logic [CODE_W-1:0]    note_code;
    logic [DUR_W-1:0]     note_dur;
    logic [PERIOD_W-1:0]  tone_p;
    logic [POS_W-1:0]     len_sat;

    assign mode = t_mode'(i_mode);

    // A tick whose note count has run out needs settled table data.
    assign load_tick  = (mode == MODE_TICK) && r_enabled && (r_ticks == '0);
    assign o_in_stall = q_full || (load_tick && (r_fresh != FRESH_DONE));
    assign accept     = i_in_valid && !o_in_stall;

    // Table writes.
    always_comb begin
        tbl_wr.note_we   = accept && (mode == MODE_NOTE_WR)
                           && ({1'b0, i_slot} < 7'(NOTE_SLOTS));
        tbl_wr.note_addr = i_slot[NOTE_AW-1:0];
        tbl_wr.note_data = {i_tone_code, i_length_ticks};
        tbl_wr.tone_we   = accept && (mode == MODE_TONE_WR)
                           && ({1'b0, i_slot} < 7'(TONE_SLOTS));
        tbl_wr.tone_addr = i_slot[TONE_AW-1:0];
        tbl_wr.tone_data = i_period_value;
    end

    tns_tables u_tables (
        .i_clk        (i_clk),
        .i_wr         (tbl_wr),
        .i_note_raddr (r_pos[NOTE_AW-1:0]),
        .o_note_q     (note_q),
        .o_tone_q     (tone_q)
    );

    // Decode the current note and its tone.
    assign note_code = note_q[NOTE_W-1 -: CODE_W];
    assign note_dur  = note_q[DUR_W-1:0];
    assign tone_p    = ({1'b0, note_code} >= 7'(TONE_SLOTS)) ? '0 : tone_q;
    assign len_sat   = (r_tune_length > 7'(NOTE_SLOTS)) ? POS_W'(NOTE_SLOTS)
                                                        : POS_W'(r_tune_length);

    // Next state for the accepted item.
    always_comb begin
        n_pos     = r_pos;
        n_ticks   = r_ticks;
        n_enabled = r_enabled;
        n_period  = r_period;
        n_compare = r_compare;
        if (accept) begin
            case (mode)
                MODE_TICK: begin
                    if (r_enabled) begin
                        if (r_ticks != '0) begin
                            n_ticks = r_ticks - DUR_W'(1);
                        end else if (r_pos >= len_sat) begin
                            // End of the tune: stop and mute, keep the period.
                            n_enabled = 1'b0;
                            n_pos     = '0;
                            n_ticks   = '0;
                            n_compare = '0;
                        end else begin
                            // The first note always sets the period, even a rest.
                            if ((note_code != r_rest_code) || (r_pos == '0)) begin
                                n_period = tone_p;
                            end
                            n_compare = (note_code == r_rest_code) ? '0
                                                                   : tone_p[PERIOD_W-1:1];
                            n_ticks   = note_dur;
                            n_pos     = r_pos + POS_W'(1);
                        end
                    end
                end
                MODE_START: begin
                    n_enabled = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Settle count of the table read chain.
    always_comb begin
        if (accept && ((mode == MODE_NOTE_WR) || (mode == MODE_TONE_WR) || load_tick)) begin
            n_fresh = '0;
        end else if (r_fresh != FRESH_DONE) begin
            n_fresh = r_fresh + 2'd1;
        end else begin
            n_fresh = r_fresh;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_ticks   <= '0;
            r_enabled <= 1'b0;
            r_period  <= '0;
            r_compare <= '0;
            r_fresh   <= '0;
        end else begin
            r_pos     <= n_pos;
            r_ticks   <= n_ticks;
            r_enabled <= n_enabled;
            r_period  <= n_period;
            r_compare <= n_compare;
            r_fresh   <= n_fresh;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tune_length <= '0;
            r_rest_code   <= 6'd63;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TUNE_LENGTH: r_tune_length <= i_cfg_data[LEN_W-1:0];
                CFG_REST_CODE:   r_rest_code   <= i_cfg_data[CODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Each item leaves one result beat with the updated state.
    assign push_data = '{period: n_period, compare: n_compare, playing: n_enabled};

    tns_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (push_data),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (out_data),
        .o_full  (q_full)
    );

    assign o_tone_period  = out_data.period;
    assign o_tone_compare = out_data.compare;
    assign o_playing      = out_data.playing;

endmodule
`default_nettype wire

// ----- hdl/tns_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tns_checker: port-level checks of the tune note sequencer
// Watches the channels of the top level and flags illegal behavior.
// ----------------------------------------------------------------------------
module tns_checker
    import tns_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_stall,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire logic [PERIOD_W-1:0]  o_tone_period,
    input wire logic [COMPARE_W-1:0] o_tone_compare,
    input wire logic                 o_playing
);

    // A stalled result beat stays and holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_tone_period)
        && $stable(o_tone_compare) && $stable(o_playing)))
        else $error("stalled result beat changed");

    // An item taken with nothing queued shows a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !o_out_valid) |=> o_out_valid)
        else $error("accepted item gave no result beat");

    // A stopped player is muted.
    a_stopped_muted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_playing) |-> (o_tone_compare == '0))
        else $error("compare value nonzero while stopped");

    // The compare value is either mute or half the period.
    a_half_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_tone_compare == '0)
                         || (o_tone_compare == o_tone_period[PERIOD_W-1:1])))
        else $error("compare value is not half the period");

endmodule

bind tune_note_sequencer tns_checker u_tns_checker (.*);
`default_nettype wire
